// File: sv/lbs_pkg.sv
// Shared types and constants for the LED blink sequencer.
// Holds the mode codes, the command codes and the request and response structs.
// No dependencies.
package lbs_pkg;

   // Width of the on, off and repeat fields of a request
   localparam int unsigned FIELD_W = 8;
   // Widest phase timer supported; timer loads zero-extend through this width
   localparam int unsigned WIDE_W  = 16;

   // Command codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SET  = 1'b1;

   // LED modes, same encoding on the request and on the response
   typedef enum logic [2:0] {
      MODE_NONE  = 3'd0,
      MODE_OFF   = 3'd1,
      MODE_ON    = 3'd2,
      MODE_BLINK = 3'd3,
      MODE_FLASH = 3'd4
   } mode_type;

   typedef struct packed {
      logic               cmd;
      logic [2:0]         req_mode;
      logic [FIELD_W-1:0] req_on_ticks;
      logic [FIELD_W-1:0] req_off_ticks;
      logic [FIELD_W-1:0] req_repeats;
   } req_type;

   typedef struct packed {
      logic       led_level;
      logic       is_busy;
      logic [2:0] active_mode;
   } rsp_type;

endpackage

// File: sv/lbs_engine.sv
// Sequencer state and per-request update logic of the LED blink sequencer.
// Depends on lbs_pkg for mode codes and the request and response structs.
// Applies one request when step_en is high and presents the updated response.
module lbs_engine #(
   parameter int unsigned TICK_WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  lbs_pkg::req_type req_item,
   output lbs_pkg::rsp_type rsp_item
);

   // Pending request
   lbs_pkg::mode_type               pend_mode_ff, pend_mode_in;
   logic [lbs_pkg::FIELD_W-1:0]     pend_on_ff, pend_on_in;
   logic [lbs_pkg::FIELD_W-1:0]     pend_off_ff, pend_off_in;
   logic [lbs_pkg::FIELD_W-1:0]     pend_repeats_ff, pend_repeats_in;

   // Mode in force and its sequence state
   lbs_pkg::mode_type               cur_mode_ff, cur_mode_in;
   logic [lbs_pkg::FIELD_W-1:0]     cur_on_ff, cur_on_in;
   logic [lbs_pkg::FIELD_W-1:0]     cur_off_ff, cur_off_in;
   logic [lbs_pkg::FIELD_W-1:0]     cycles_left_ff, cycles_left_in;
   logic [TICK_WIDTH-1:0]           phase_timer_ff, phase_timer_in;
   logic                            lit_ff, lit_in;
   logic                            in_on_phase_ff, in_on_phase_in;
   logic                            update_locked_ff, update_locked_in;
   logic                            seq_running_ff, seq_running_in;

   // Timer loads, truncated or zero-extended to the timer width
   logic [lbs_pkg::WIDE_W-1:0]      pend_on_wide, cur_on_wide, cur_off_wide;
   logic [TICK_WIDTH-1:0]           pend_on_load, cur_on_load, cur_off_load;
   logic                            cur_is_seq;

   assign pend_on_wide = {{(lbs_pkg::WIDE_W - lbs_pkg::FIELD_W){1'b0}}, pend_on_ff};
   assign cur_on_wide  = {{(lbs_pkg::WIDE_W - lbs_pkg::FIELD_W){1'b0}}, cur_on_ff};
   assign cur_off_wide = {{(lbs_pkg::WIDE_W - lbs_pkg::FIELD_W){1'b0}}, cur_off_ff};
   assign pend_on_load = pend_on_wide[TICK_WIDTH-1:0];
   assign cur_on_load  = cur_on_wide[TICK_WIDTH-1:0];
   assign cur_off_load = cur_off_wide[TICK_WIDTH-1:0];
   assign cur_is_seq   = (cur_mode_ff == lbs_pkg::MODE_BLINK) ||
                         (cur_mode_ff == lbs_pkg::MODE_FLASH);

   // Compute the state after one request
   always_comb begin
      pend_mode_in     = pend_mode_ff;
      pend_on_in       = pend_on_ff;
      pend_off_in      = pend_off_ff;
      pend_repeats_in  = pend_repeats_ff;
      cur_mode_in      = cur_mode_ff;
      cur_on_in        = cur_on_ff;
      cur_off_in       = cur_off_ff;
      cycles_left_in   = cycles_left_ff;
      phase_timer_in   = phase_timer_ff;
      lit_in           = lit_ff;
      in_on_phase_in   = in_on_phase_ff;
      update_locked_in = update_locked_ff;
      seq_running_in   = seq_running_ff;

      if (req_item.cmd == lbs_pkg::CMD_SET) begin
         // Store the pending request; drop undefined mode codes
         if (req_item.req_mode <= lbs_pkg::MODE_FLASH) begin
            pend_mode_in    = lbs_pkg::mode_type'(req_item.req_mode);
            pend_on_in      = req_item.req_on_ticks;
            pend_off_in     = req_item.req_off_ticks;
            pend_repeats_in = req_item.req_repeats;
         end
      end else if (pend_mode_ff != lbs_pkg::MODE_NONE && !update_locked_ff) begin
         // Adopt the pending request
         cur_mode_in    = pend_mode_ff;
         cur_on_in      = pend_on_ff;
         cur_off_in     = pend_off_ff;
         cycles_left_in = pend_repeats_ff;
         pend_mode_in   = lbs_pkg::MODE_NONE;
         if (pend_mode_ff == lbs_pkg::MODE_ON || pend_mode_ff == lbs_pkg::MODE_OFF) begin
            lit_in           = (pend_mode_ff == lbs_pkg::MODE_ON);
            phase_timer_in   = '0;
            in_on_phase_in   = 1'b0;
            update_locked_in = 1'b0;
            seq_running_in   = 1'b0;
         end else begin
            lit_in           = 1'b1;
            phase_timer_in   = pend_on_load;
            in_on_phase_in   = 1'b1;
            update_locked_in = 1'b1;
            seq_running_in   = 1'b1;
         end
      end else begin
         // Advance a running sequence
         if (cur_is_seq) begin
            phase_timer_in = phase_timer_ff - 1'b1;
            if (!in_on_phase_ff) begin
               update_locked_in = 1'b0;
            end
            if (phase_timer_in == '0) begin
               if (in_on_phase_ff) begin
                  // End of on phase: go dark, load off time (at least one tick)
                  lit_in         = !lit_ff;
                  in_on_phase_in = 1'b0;
                  phase_timer_in = (cur_off_load == '0) ? TICK_WIDTH'(1) : cur_off_load;
               end else begin
                  // End of off phase: count the cycle, then stop or relight
                  if (cycles_left_ff != '0) begin
                     cycles_left_in = cycles_left_ff - 1'b1;
                     if (cycles_left_in == '0) begin
                        cur_mode_in    = lbs_pkg::MODE_OFF;
                        seq_running_in = 1'b0;
                     end
                  end
                  if (cur_off_ff == '0) begin
                     cur_mode_in    = lbs_pkg::MODE_OFF;
                     seq_running_in = 1'b0;
                  end else begin
                     lit_in         = !lit_ff;
                     in_on_phase_in = 1'b1;
                     phase_timer_in = cur_on_load;
                  end
               end
            end
         end
         // Force the level for the static modes
         if (cur_mode_in == lbs_pkg::MODE_ON) begin
            lit_in = 1'b1;
         end else if (cur_mode_in == lbs_pkg::MODE_OFF) begin
            lit_in = 1'b0;
         end
      end
   end

   // Report the state after the request
   always_comb begin
      rsp_item.led_level   = lit_in;
      rsp_item.is_busy     = (pend_mode_in != lbs_pkg::MODE_NONE) || seq_running_in;
      rsp_item.active_mode = cur_mode_in;
   end

   // Commit the new state
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_mode_ff     <= lbs_pkg::MODE_NONE;
         pend_on_ff       <= '0;
         pend_off_ff      <= '0;
         pend_repeats_ff  <= '0;
         cur_mode_ff      <= lbs_pkg::MODE_NONE;
         cur_on_ff        <= '0;
         cur_off_ff       <= '0;
         cycles_left_ff   <= '0;
         phase_timer_ff   <= '0;
         lit_ff           <= 1'b0;
         in_on_phase_ff   <= 1'b0;
         update_locked_ff <= 1'b0;
         seq_running_ff   <= 1'b0;
      end else if (step_en) begin
         pend_mode_ff     <= pend_mode_in;
         pend_on_ff       <= pend_on_in;
         pend_off_ff      <= pend_off_in;
         pend_repeats_ff  <= pend_repeats_in;
         cur_mode_ff      <= cur_mode_in;
         cur_on_ff        <= cur_on_in;
         cur_off_ff       <= cur_off_in;
         cycles_left_ff   <= cycles_left_in;
         phase_timer_ff   <= phase_timer_in;
         lit_ff           <= lit_in;
         in_on_phase_ff   <= in_on_phase_in;
         update_locked_ff <= update_locked_in;
         seq_running_ff   <= seq_running_in;
      end
   end

   // A sequence runs exactly while blink or flash is in force
   assert property (@(posedge clock) disable iff (reset)
      seq_running_ff == cur_is_seq)
      else $error("sequence flag disagrees with mode in force");

   // The update lock is only held by a running sequence
   assert property (@(posedge clock) disable iff (reset)
      update_locked_ff |-> seq_running_ff)
      else $error("update lock held without a running sequence");

   // While a sequence runs the LED is lit exactly in the on phase
   assert property (@(posedge clock) disable iff (reset)
      seq_running_ff |-> (lit_ff == in_on_phase_ff))
      else $error("LED level out of step with phase");

endmodule

// File: sv/led_blink_sequencer_core.sv
// Top level of the LED blink sequencer: request slot, result register, handshakes.
// Depends on lbs_pkg and lbs_engine.
//
// The core takes one request (tick or set) per clock and returns exactly one
// response per request. A request is held in an input register until the
// result register can take its response, applied to the sequencer state by
// lbs_engine, and the resulting LED level, busy flag and mode in force land in
// a result register: rsp_valid rises in the cycle after the request is applied.
// Requests stream at one per cycle as long as the result register drains. When
// rsp_stall holds a result, req_stall rises as soon as the input register also
// holds a request (at once when streaming), so at most two requests are in flight.
// The phase timer is TICK_WIDTH bits wide and wraps; loaded on/off times keep
// their low TICK_WIDTH bits.
module led_blink_sequencer_core #(
   parameter int unsigned TICK_WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lbs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lbs_pkg::rsp_type rsp_data
);

   logic             in_valid_ff, in_valid_in;
   lbs_pkg::req_type in_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   lbs_pkg::rsp_type rsp_data_ff;
   lbs_pkg::rsp_type step_rsp;
   logic             out_free;
   logic             advance;

   // Move a request on when the result register can take its response
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // Apply the held request to the sequencer state
   lbs_engine #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .req_item (in_data_ff),
      .rsp_item (step_rsp)
   );

   // Next valid flags of the two registers
   always_comb begin
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // Hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture request and response payloads
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Every applied request leaves a response in the result register
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("applied request produced no response");

   // The input register only stalls while a response waits
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("request stalled with the result register free");

   // A stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(rsp_data_ff))
      else $error("stalled response changed");

endmodule

// File: test/testbench.sv
// Testbench for led_blink_sequencer_core: directed table, then random requests over idling phases.
// Depends on lbs_pkg and the core; predicts untyped responses with its own model of the LED state.
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned TICK_W      = 8;
   localparam int          RAND_PER_PH = 488;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          HOLD_CYCLES = 300;
   localparam int          TAIL_CYCLES = 8;
   // Mode code outside the legal range, ignored by a set request
   localparam logic [2:0]  MODE_BAD    = 3'd7;

   typedef struct {
      lbs_pkg::req_type req;
      bit               typed;
      lbs_pkg::rsp_type rsp;
   } led_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   lbs_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   lbs_pkg::rsp_type rsp_data;

   // Predicted LED state
   lbs_pkg::mode_type             queued_mode = lbs_pkg::MODE_NONE;
   logic [lbs_pkg::FIELD_W-1:0]   queued_on   = '0;
   logic [lbs_pkg::FIELD_W-1:0]   queued_off  = '0;
   logic [lbs_pkg::FIELD_W-1:0]   queued_reps = '0;
   lbs_pkg::mode_type             run_mode    = lbs_pkg::MODE_NONE;
   logic [lbs_pkg::FIELD_W-1:0]   run_on      = '0;
   logic [lbs_pkg::FIELD_W-1:0]   run_off     = '0;
   logic [lbs_pkg::FIELD_W-1:0]   reps_left   = '0;
   logic [TICK_W-1:0]             phase_cnt   = '0;
   logic                          led_lit     = 1'b0;
   logic                          on_phase    = 1'b0;
   logic                          adopt_lock  = 1'b0;
   logic                          seq_active  = 1'b0;

   lbs_pkg::rsp_type led_expect_q[$];
   led_row_type      led_dir_q[$];

   int idle_pct    = 0;
   int stall_pct   = 0;
   int hold_left   = 0;
   bit hold_go     = 1'b0;
   int cycle_cnt   = 0;
   int err_cnt     = 0;
   int sent_cnt    = 0;
   int checked_cnt = 0;
   int seq_cnt     = 0;

   led_blink_sequencer_core #(.TICK_WIDTH(TICK_W)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
   end

   // Apply one request to the predicted state and return the LED response
   function automatic lbs_pkg::rsp_type advance_led(lbs_pkg::req_type r);
      lbs_pkg::rsp_type o;
      if (r.cmd == lbs_pkg::CMD_SET) begin
         if (r.req_mode <= lbs_pkg::MODE_FLASH) begin
            queued_mode = lbs_pkg::mode_type'(r.req_mode);
            queued_on   = r.req_on_ticks;
            queued_off  = r.req_off_ticks;
            queued_reps = r.req_repeats;
         end
      end else if (queued_mode != lbs_pkg::MODE_NONE && !adopt_lock) begin
         // adopt the pending request
         run_mode    = queued_mode;
         run_on      = queued_on;
         run_off     = queued_off;
         reps_left   = queued_reps;
         queued_mode = lbs_pkg::MODE_NONE;
         if (run_mode == lbs_pkg::MODE_ON || run_mode == lbs_pkg::MODE_OFF) begin
            led_lit    = (run_mode == lbs_pkg::MODE_ON);
            phase_cnt  = '0;
            on_phase   = 1'b0;
            adopt_lock = 1'b0;
            seq_active = 1'b0;
         end else begin
            led_lit    = 1'b1;
            phase_cnt  = TICK_W'(run_on);
            on_phase   = 1'b1;
            adopt_lock = 1'b1;
            seq_active = 1'b1;
            seq_cnt++;
         end
      end else begin
         // run the phase timer of a blink or flash sequence
         if (run_mode == lbs_pkg::MODE_BLINK || run_mode == lbs_pkg::MODE_FLASH) begin
            phase_cnt = phase_cnt - 1'b1;
            if (!on_phase) adopt_lock = 1'b0;
            if (phase_cnt == '0) begin
               if (on_phase) begin
                  led_lit   = ~led_lit;
                  on_phase  = 1'b0;
                  phase_cnt = TICK_W'(run_off);
                  if (phase_cnt == '0) phase_cnt = TICK_W'(1);
               end else begin
                  if (reps_left != '0) begin
                     reps_left = reps_left - 1'b1;
                     if (reps_left == '0) begin
                        run_mode   = lbs_pkg::MODE_OFF;
                        seq_active = 1'b0;
                     end
                  end
                  if (run_off == '0) begin
                     run_mode   = lbs_pkg::MODE_OFF;
                     seq_active = 1'b0;
                  end else begin
                     led_lit   = ~led_lit;
                     on_phase  = 1'b1;
                     phase_cnt = TICK_W'(run_on);
                  end
               end
            end
         end
         if (run_mode == lbs_pkg::MODE_ON) led_lit = 1'b1;
         else if (run_mode == lbs_pkg::MODE_OFF) led_lit = 1'b0;
      end
      o.led_level   = led_lit;
      o.is_busy     = (queued_mode != lbs_pkg::MODE_NONE) || seq_active;
      o.active_mode = run_mode;
      return o;
   endfunction

   function automatic led_row_type mk_row(logic cmd, logic [2:0] mode, logic [7:0] on_t,
                                          logic [7:0] off_t, logic [7:0] reps, bit typed,
                                          logic lvl, logic busy, logic [2:0] am);
      led_row_type row;
      row.req.cmd           = cmd;
      row.req.req_mode      = mode;
      row.req.req_on_ticks  = on_t;
      row.req.req_off_ticks = off_t;
      row.req.req_repeats   = reps;
      row.typed             = typed;
      row.rsp.led_level     = lvl;
      row.rsp.is_busy       = busy;
      row.rsp.active_mode   = am;
      return row;
   endfunction

   // Draw a random request: mostly ticks, sets biased toward short sequences
   function automatic lbs_pkg::req_type rand_led_req();
      lbs_pkg::req_type r;
      int               pick;
      r.cmd           = lbs_pkg::CMD_TICK;
      r.req_mode      = 3'($urandom);
      r.req_on_ticks  = 8'($urandom);
      r.req_off_ticks = 8'($urandom);
      r.req_repeats   = 8'($urandom);
      if ($urandom_range(99) < 72) return r;
      r.cmd = lbs_pkg::CMD_SET;
      pick  = $urandom_range(99);
      if (pick < 35)      r.req_mode = lbs_pkg::MODE_BLINK;
      else if (pick < 70) r.req_mode = lbs_pkg::MODE_FLASH;
      else if (pick < 80) r.req_mode = lbs_pkg::MODE_ON;
      else if (pick < 88) r.req_mode = lbs_pkg::MODE_OFF;
      else if (pick < 94) r.req_mode = lbs_pkg::MODE_NONE;
      else                r.req_mode = 3'($urandom_range(5, 7));
      // long on phases lock out adoption for a long time, keep them rare
      pick = $urandom_range(999);
      if (pick < 5)       r.req_on_ticks = 8'($urandom_range(255));
      else if (pick < 10) r.req_on_ticks = '0;
      else                r.req_on_ticks = 8'($urandom_range(1, 6));
      pick = $urandom_range(99);
      if (pick < 4)       r.req_off_ticks = 8'($urandom_range(255));
      else if (pick < 20) r.req_off_ticks = '0;
      else                r.req_off_ticks = 8'($urandom_range(1, 6));
      pick = $urandom_range(99);
      if (pick < 10)      r.req_repeats = 8'($urandom_range(255));
      else if (pick < 40) r.req_repeats = '0;
      else                r.req_repeats = 8'($urandom_range(1, 4));
      return r;
   endfunction

   // Offer one request, wait for acceptance, then record its response
   task automatic send_led_req(lbs_pkg::req_type r, bit typed, lbs_pkg::rsp_type typed_rsp);
      lbs_pkg::rsp_type p;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      p = advance_led(r);
      led_expect_q.push_back(typed ? typed_rsp : p);
      sent_cnt++;
   endtask

   // Drop valid and hold until every outstanding response has come back
   task automatic wait_led_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (led_expect_q.size() != 0);
   endtask

   // Receiver: random stall, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_go) begin
         hold_left = HOLD_CYCLES;
         hold_go   = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      lbs_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (led_expect_q.size() == 0) begin
            err_cnt++;
            $display("%0t: response with no request outstanding: led %0d busy %0d mode %0d",
                     $time, rsp_data.led_level, rsp_data.is_busy, rsp_data.active_mode);
         end else begin
            want = led_expect_q.pop_front();
            checked_cnt++;
            if (want.led_level !== rsp_data.led_level) begin
               err_cnt++;
               $display("%0t: led_level expected %0d actual %0d",
                        $time, want.led_level, rsp_data.led_level);
            end
            if (want.is_busy !== rsp_data.is_busy) begin
               err_cnt++;
               $display("%0t: is_busy expected %0d actual %0d",
                        $time, want.is_busy, rsp_data.is_busy);
            end
            if (want.active_mode !== rsp_data.active_mode) begin
               err_cnt++;
               $display("%0t: active_mode expected %0d actual %0d",
                        $time, want.active_mode, rsp_data.active_mode);
            end
         end
      end
   end

   // Stop a hung run
   initial begin
      wait (cycle_cnt >= CYCLE_LIMIT);
      $display("%0t: timeout after %0d cycles, %0d responses outstanding",
               $time, cycle_cnt, led_expect_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      lbs_pkg::rsp_type none_rsp;
      none_rsp = '0;

      // directed table: typed responses where they follow directly
      led_dir_q.push_back(mk_row(lbs_pkg::CMD_TICK, lbs_pkg::MODE_NONE, 8'd0, 8'd0, 8'd0,
                                 1'b1, 1'b0, 1'b0, lbs_pkg::MODE_NONE));
      led_dir_q.push_back(mk_row(lbs_pkg::CMD_SET, MODE_BAD, 8'd255, 8'd255, 8'd255,
                                 1'b1, 1'b0, 1'b0, lbs_pkg::MODE_NONE));
      led_dir_q.push_back(mk_row(lbs_pkg::CMD_SET, lbs_pkg::MODE_ON, 8'd0, 8'd0, 8'd0,
                                 1'b1, 1'b0, 1'b1, lbs_pkg::MODE_NONE));
      led_dir_q.push_back(mk_row(lbs_pkg::CMD_TICK, lbs_pkg::MODE_NONE, 8'd0, 8'd0, 8'd0,
                                 1'b1, 1'b1, 1'b0, lbs_pkg::MODE_ON));
      led_dir_q.push_back(mk_row(lbs_pkg::CMD_SET, lbs_pkg::MODE_NONE, 8'd255, 8'd255, 8'd255,
                                 1'b1, 1'b1, 1'b0, lbs_pkg::MODE_ON));
      led_dir_q.push_back(mk_row(lbs_pkg::CMD_TICK, lbs_pkg::MODE_NONE, 8'd0, 8'd0, 8'd0,
                                 1'b1, 1'b1, 1'b0, lbs_pkg::MODE_ON));
      led_dir_q.push_back(mk_row(lbs_pkg::CMD_SET, lbs_pkg::MODE_OFF, 8'd0, 8'd0, 8'd0,
                                 1'b1, 1'b1, 1'b1, lbs_pkg::MODE_ON));
      led_dir_q.push_back(mk_row(lbs_pkg::CMD_TICK, lbs_pkg::MODE_NONE, 8'd0, 8'd0, 8'd0,
                                 1'b1, 1'b0, 1'b0, lbs_pkg::MODE_OFF));
      // blink with two repeats, run to completion
      led_dir_q.push_back(mk_row(lbs_pkg::CMD_SET, lbs_pkg::MODE_BLINK, 8'd2, 8'd1, 8'd2,
                                 1'b0, 1'b0, 1'b0, lbs_pkg::MODE_NONE));
      repeat (8) led_dir_q.push_back(mk_row(lbs_pkg::CMD_TICK, lbs_pkg::MODE_NONE,
                                            8'd0, 8'd0, 8'd0,
                                            1'b0, 1'b0, 1'b0, lbs_pkg::MODE_NONE));
      // flash with zero off time: single pulse
      led_dir_q.push_back(mk_row(lbs_pkg::CMD_SET, lbs_pkg::MODE_FLASH, 8'd1, 8'd0, 8'd0,
                                 1'b0, 1'b0, 1'b0, lbs_pkg::MODE_NONE));
      repeat (3) led_dir_q.push_back(mk_row(lbs_pkg::CMD_TICK, lbs_pkg::MODE_NONE,
                                            8'd0, 8'd0, 8'd0,
                                            1'b0, 1'b0, 1'b0, lbs_pkg::MODE_NONE));
      // widest blink, then a set that the lock keeps pending
      led_dir_q.push_back(mk_row(lbs_pkg::CMD_SET, lbs_pkg::MODE_BLINK, 8'd255, 8'd255, 8'd255,
                                 1'b0, 1'b0, 1'b0, lbs_pkg::MODE_NONE));
      led_dir_q.push_back(mk_row(lbs_pkg::CMD_TICK, lbs_pkg::MODE_NONE, 8'd0, 8'd0, 8'd0,
                                 1'b0, 1'b0, 1'b0, lbs_pkg::MODE_NONE));
      led_dir_q.push_back(mk_row(lbs_pkg::CMD_SET, lbs_pkg::MODE_ON, 8'd0, 8'd0, 8'd0,
                                 1'b0, 1'b0, 1'b0, lbs_pkg::MODE_NONE));
      led_dir_q.push_back(mk_row(lbs_pkg::CMD_TICK, lbs_pkg::MODE_NONE, 8'd0, 8'd0, 8'd0,
                                 1'b0, 1'b0, 1'b0, lbs_pkg::MODE_NONE));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (led_dir_q[i]) send_led_req(led_dir_q[i].req, led_dir_q[i].typed,
                                          led_dir_q[i].rsp);
      wait_led_drain();

      // random phases: long receiver hold-off only, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
               hold_go   = 1'b1;
            end
            1: begin
               idle_pct  = 51;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 51;
            end
            default: begin
               idle_pct  = 18;
               stall_pct = 18;
            end
         endcase
         repeat (RAND_PER_PH) send_led_req(rand_led_req(), 1'b0, none_rsp);
         wait_led_drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d requests (%0d sequences started) over four idling phases;",
               sent_cnt, seq_cnt);
      $display("checked %0d responses, %0d left outstanding.", checked_cnt,
               led_expect_q.size());
      if (err_cnt == 0 && led_expect_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
